// ----- design/pwmm_pkg.sv -----
// Package for the PostgreSQL wire message monitor: codes, report type,
// message type tables and CommandComplete word classification.
// No dependencies; every other design file but pwmm_if imports it.
package pwmm_pkg;

	localparam logic [31:0] ENCRYPT_CODE_MIN = 32'h04d2_0000;

	localparam logic [47:0] PAT_VERROR   = 48'h5645_5252_4F52;
	localparam logic [63:0] PAT_VWARNING = 64'h5657_4152_4E49_4E47;

	localparam logic [63:0] WORD_BEGIN    = 64'h0000_0042_4547_494E;
	localparam logic [63:0] WORD_START    = 64'h0000_0053_5441_5254;
	localparam logic [63:0] WORD_COMMIT   = 64'h0000_434F_4D4D_4954;
	localparam logic [63:0] WORD_ROLLBACK = 64'h524F_4C4C_4241_434B;
	localparam logic [63:0] WORD_SELECT   = 64'h0000_5345_4C45_4354;
	localparam logic [63:0] WORD_INSERT   = 64'h0000_494E_5345_5254;
	localparam logic [63:0] WORD_UPDATE   = 64'h0000_5550_4441_5445;
	localparam logic [63:0] WORD_DELETE   = 64'h0000_4445_4C45_5445;

	localparam logic [7:0] TYPE_TERMINATE = 8'h58; // 'X'
	localparam logic [7:0] TYPE_COMMAND   = 8'h43; // 'C'
	localparam logic [7:0] TYPE_ERROR     = 8'h45; // 'E'
	localparam logic [7:0] TYPE_NOTICE    = 8'h4E; // 'N'
	localparam logic [7:0] TYPE_AUTH      = 8'h52; // 'R'
	localparam logic [7:0] CHAR_SPACE     = 8'h20;

	localparam logic [3:0] WORD_MAX = 4'd8;
	localparam logic [3:0] WORD_OVER = 4'd9;

	typedef enum logic [1:0] {
		PH_TYPE    = 2'd0,
		PH_LEN     = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_STARTUP = 2'd0,
		KIND_KNOWN   = 2'd1,
		KIND_UNKNOWN = 2'd2,
		KIND_ENCRYPT = 2'd3
	} msg_kind_t;

	typedef enum logic [3:0] {
		CLS_NONE     = 4'd0,
		CLS_SELECT   = 4'd1,
		CLS_INSERT   = 4'd2,
		CLS_UPDATE   = 4'd3,
		CLS_DELETE   = 4'd4,
		CLS_BEGIN    = 4'd5,
		CLS_COMMIT   = 4'd6,
		CLS_ROLLBACK = 4'd7,
		CLS_OTHER    = 4'd8
	} stmt_class_t;

	typedef struct packed {
		logic        direction;
		logic [7:0]  msg_type;
		logic [31:0] msg_len;
		msg_kind_t   kind;
		stmt_class_t cls;
		logic        commit;
		logic        rollback;
		logic        err;
		logic        warn;
		logic        auth;
		logic        in_txn;
	} report_t;

	// framer -> scanner control
	typedef struct packed {
		logic step;
		logic restart;
		logic shift;
	} scan_ctl_t;

	// scanner state as seen after the current byte
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  count;
		logic        err_hit;
		logic        warn_hit;
		logic        nonzero;
	} scan_view_t;

	function automatic logic fe_known(input logic [7:0] t);
		logic hit;
		unique case (t)
			8'h42, 8'h43, 8'h64, 8'h63, 8'h66, 8'h44, 8'h45,
			8'h48, 8'h46, 8'h70, 8'h50, 8'h51, 8'h53, 8'h58: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic be_known(input logic [7:0] t);
		logic hit;
		unique case (t)
			8'h52, 8'h4B, 8'h32, 8'h33, 8'h43, 8'h64, 8'h63, 8'h47,
			8'h48, 8'h44, 8'h49, 8'h45, 8'h56, 8'h76, 8'h6E, 8'h4E,
			8'h41, 8'h74, 8'h53, 8'h31, 8'h73, 8'h5A, 8'h54: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic stmt_class_t classify(input logic [63:0] word, input logic [3:0] count);
		stmt_class_t cls;
		cls = CLS_OTHER;
		if (count == 4'd5 && (word == WORD_BEGIN || word == WORD_START))
			cls = CLS_BEGIN;
		else if (count == 4'd8 && word == WORD_ROLLBACK)
			cls = CLS_ROLLBACK;
		else if (count == 4'd6) begin
			if (word == WORD_COMMIT)
				cls = CLS_COMMIT;
			else if (word == WORD_SELECT)
				cls = CLS_SELECT;
			else if (word == WORD_INSERT)
				cls = CLS_INSERT;
			else if (word == WORD_UPDATE)
				cls = CLS_UPDATE;
			else if (word == WORD_DELETE)
				cls = CLS_DELETE;
		end
		return cls;
	endfunction

endpackage

// ----- design/pwmm_if.sv -----
// Channel interfaces of the wire message monitor: the byte stream in and
// the per-message report out. Valid/ready handshake. No dependencies.
interface pwmm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       from_frontend;

	modport source (output valid, data_byte, from_frontend, input ready);
	modport sink (input valid, data_byte, from_frontend, output ready);
endinterface

interface pwmm_report_if;
	logic        valid;
	logic        ready;
	logic        direction;
	logic [7:0]  message_type;
	logic [31:0] message_length;
	logic [1:0]  message_kind;
	logic [3:0]  statement_class;
	logic        commit_counted;
	logic        rollback_counted;
	logic        error_seen;
	logic        warning_seen;
	logic        auth_ok;
	logic        in_transaction_now;

	modport source (output valid, direction, message_type, message_length, message_kind,
		statement_class, commit_counted, rollback_counted, error_seen, warning_seen,
		auth_ok, in_transaction_now, input ready);
	modport sink (input valid, direction, message_type, message_length, message_kind,
		statement_class, commit_counted, rollback_counted, error_seen, warning_seen,
		auth_ok, in_transaction_now, output ready);
endinterface

// ----- design/pwmm_scan.sv -----
// Backend payload scanner: CommandComplete first word, VERROR/VWARNING
// window match and nonzero-payload flag. Depends on pwmm_pkg.
module pwmm_scan
	import pwmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  scan_ctl_t  ctl,
	input  logic [7:0] data,
	output scan_view_t view
);

	logic [63:0] word_q, tail_q, tail_n;
	logic [3:0]  count_q;
	logic        closed_q, closed_n;
	logic        err_q, warn_q, nz_q;

	always_comb begin
		view.word     = word_q;
		view.count    = count_q;
		view.err_hit  = err_q;
		view.warn_hit = warn_q;
		view.nonzero  = nz_q;
		closed_n      = closed_q;
		tail_n        = tail_q;
		if (ctl.shift) begin
			if (!closed_q) begin
				if (data == CHAR_SPACE || data == 8'h00) begin
					closed_n = 1'b1;
				end else if (count_q < WORD_MAX) begin
					view.word  = {word_q[55:0], data};
					view.count = count_q + 4'd1;
				end else begin
					view.count = WORD_OVER;
				end
			end
			tail_n = {tail_q[55:0], data};
			if (tail_n[47:0] == PAT_VERROR)
				view.err_hit = 1'b1;
			if (tail_n == PAT_VWARNING)
				view.warn_hit = 1'b1;
			if (data != 8'h00)
				view.nonzero = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			err_q    <= 1'b0;
			warn_q   <= 1'b0;
			nz_q     <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.restart) begin
				word_q   <= '0;
				tail_q   <= '0;
				count_q  <= '0;
				closed_q <= 1'b0;
				err_q    <= 1'b0;
				warn_q   <= 1'b0;
				nz_q     <= 1'b0;
			end else begin
				word_q   <= view.word;
				tail_q   <= tail_n;
				count_q  <= view.count;
				closed_q <= closed_n;
				err_q    <= view.err_hit;
				warn_q   <= view.warn_hit;
				nz_q     <= view.nonzero;
			end
		end
	end

endmodule

// ----- design/pwmm_framer.sv -----
// Per-direction message framer and report builder. Holds the startup,
// encryption and transaction state. Depends on pwmm_pkg and pwmm_scan.
module pwmm_framer
	import pwmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       step,
	input  logic [7:0] data,
	input  logic       dir,
	output logic       res_valid,
	output report_t    res
);

	typedef struct packed {
		phase_t      phase;
		logic        is_startup;
		logic [7:0]  msg_type;
		logic [31:0] length;
		logic [31:0] seen;
	} frame_t;

	frame_t      frame_q [2];
	logic        pending_q, encrypted_q, txn_q;
	logic [31:0] code_q;

	frame_t      f, fn;
	logic        pending_n, encrypted_n, txn_n;
	logic [31:0] code_n, seen_inc, len_sh, len_fix;
	logic        done;
	scan_ctl_t   sctl;
	scan_view_t  sv;
	stmt_class_t cls;

	pwmm_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.data   (data),
		.view   (sv)
	);

	always_comb begin
		f            = frame_q[dir];
		fn           = f;
		pending_n    = pending_q;
		encrypted_n  = encrypted_q;
		txn_n        = txn_q;
		code_n       = code_q;
		done         = 1'b0;
		seen_inc     = f.seen + 32'd1;
		len_sh       = {f.length[23:0], data};
		len_fix      = (len_sh < 32'd4) ? 32'd4 : len_sh;
		sctl.step    = step;
		sctl.restart = 1'b0;
		sctl.shift   = 1'b0;
		cls          = classify(sv.word, sv.count);
		res          = '0;

		if (!encrypted_q) begin
			unique case (f.phase)
				PH_PAYLOAD: begin
					if (f.is_startup && f.seen < 32'd4)
						code_n = {code_q[23:0], data};
					sctl.shift = !dir;
					fn.seen    = seen_inc;
					if (seen_inc >= f.length - 32'd4)
						done = 1'b1;
				end
				PH_LEN: begin
					if (seen_inc >= 32'd4) begin
						fn.length = len_fix;
						fn.seen   = '0;
						if (len_fix == 32'd4)
							done = 1'b1;
						else
							fn.phase = PH_PAYLOAD;
					end else begin
						fn.length = len_sh;
						fn.seen   = seen_inc;
					end
				end
				default: begin
					// message start; unused phase code lands here too
					sctl.restart = !dir;
					fn.phase     = PH_LEN;
					if (pending_q) begin
						pending_n     = 1'b0;
						code_n        = '0;
						fn.is_startup = 1'b1;
						fn.msg_type   = '0;
						fn.length     = {24'd0, data};
						fn.seen       = 32'd1;
					end else begin
						fn.is_startup = 1'b0;
						fn.msg_type   = data;
						fn.length     = '0;
						fn.seen       = '0;
					end
				end
			endcase
		end

		if (done) begin
			fn.phase      = PH_TYPE;
			res.direction = dir;
			res.msg_len   = fn.length;
			res.cls       = CLS_NONE;
			if (fn.is_startup) begin
				if (code_n >= ENCRYPT_CODE_MIN) begin
					encrypted_n = 1'b1;
					res.kind    = KIND_ENCRYPT;
				end else begin
					res.kind = KIND_STARTUP;
				end
			end else begin
				res.msg_type = fn.msg_type;
				if (dir) begin
					res.kind = fe_known(fn.msg_type) ? KIND_KNOWN : KIND_UNKNOWN;
					if (fn.msg_type == TYPE_TERMINATE && txn_q) begin
						txn_n        = 1'b0;
						res.rollback = 1'b1;
					end
				end else begin
					res.kind = be_known(fn.msg_type) ? KIND_KNOWN : KIND_UNKNOWN;
					unique case (fn.msg_type)
						TYPE_COMMAND: begin
							res.cls = cls;
							if (cls == CLS_BEGIN)
								txn_n = 1'b1;
							else if (cls == CLS_ROLLBACK) begin
								txn_n        = 1'b0;
								res.rollback = 1'b1;
							end else begin
								if (cls == CLS_COMMIT)
									txn_n = 1'b0;
								res.commit = 1'b1;
							end
						end
						TYPE_ERROR:  res.err  = sv.err_hit;
						TYPE_NOTICE: res.warn = sv.warn_hit;
						TYPE_AUTH:   res.auth = (fn.length == 32'd8) && !sv.nonzero;
						default: ;
					endcase
				end
			end
			res.in_txn = txn_n;
		end
	end

	assign res_valid = valid && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q[0]  <= '0;
			frame_q[1]  <= '0;
			pending_q   <= 1'b1;
			encrypted_q <= 1'b0;
			txn_q       <= 1'b0;
			code_q      <= '0;
		end else if (step) begin
			frame_q[dir] <= fn;
			pending_q    <= pending_n;
			encrypted_q  <= encrypted_n;
			txn_q        <= txn_n;
			code_q       <= code_n;
		end
	end

endmodule

// ----- design/postgres_wire_message_monitor.sv -----
// Top level of the PostgreSQL wire message monitor: input register,
// framer and report output register. Depends on pwmm_pkg, pwmm_if, pwmm_framer.
//
//  channel  dir  carries                               per transfer
//  stream   in   data_byte, from_frontend              one stream byte
//  report   out  message fields and event flags        one completed message
//
// One byte per cycle sustained unless a waiting report stalls the input. A
// byte sits in the input register, goes through the framer and its report
// lands in the output register. Reset clears framing, startup, encryption and
// transaction state at once. A waiting report stalls the input only when the
// next byte also completes a message; other bytes keep flowing. After an
// encryption request bytes are still taken but dropped.
module postgres_wire_message_monitor
	import pwmm_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	pwmm_byte_if.sink     stream,
	pwmm_report_if.source report
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       dir_s1;
	logic       out_valid_q;
	report_t    report_q;
	logic       res_valid;
	report_t    res;
	logic       advance;

	assign advance      = valid_s1 && (!res_valid || !out_valid_q || report.ready);
	assign stream.ready = !valid_s1 || advance;

	pwmm_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.step      (advance),
		.data      (byte_s1),
		.dir       (dir_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
			dir_s1  <= stream.from_frontend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			report_q <= res;
	end

	assign report.valid              = out_valid_q;
	assign report.direction          = report_q.direction;
	assign report.message_type       = report_q.msg_type;
	assign report.message_length     = report_q.msg_len;
	assign report.message_kind       = report_q.kind;
	assign report.statement_class    = report_q.cls;
	assign report.commit_counted     = report_q.commit;
	assign report.rollback_counted   = report_q.rollback;
	assign report.error_seen         = report_q.err;
	assign report.warning_seen       = report_q.warn;
	assign report.auth_ok            = report_q.auth;
	assign report.in_transaction_now = report_q.in_txn;

endmodule

// ----- design/pwmm_checker.sv -----
// Port-level checks on the monitor's report channel, bound to the top level.
// Depends on pwmm_pkg.
module pwmm_checker
	import pwmm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        r_valid,
	input logic        r_ready,
	input logic        r_direction,
	input logic [7:0]  r_type,
	input logic [31:0] r_len,
	input logic [1:0]  r_kind,
	input logic [3:0]  r_class,
	input logic        r_commit,
	input logic        r_rollback,
	input logic        r_err,
	input logic        r_warn,
	input logic        r_auth,
	input logic        r_txn
);

	logic [52:0] payload;
	assign payload = {r_direction, r_type, r_len, r_kind, r_class, r_commit, r_rollback,
		r_err, r_warn, r_auth, r_txn};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(payload))
		else $error("report changed while stalled");

	a_class_only_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_class != CLS_NONE |-> !r_direction && r_type == TYPE_COMMAND)
		else $error("statement class on a non-CommandComplete message");

	a_auth_shape: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_auth |-> !r_direction && r_type == TYPE_AUTH && r_len == 32'd8)
		else $error("auth_ok on a malformed message");

	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_len >= 32'd4)
		else $error("reported length below minimum");

	a_encrypt_last: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_ready && r_kind == KIND_ENCRYPT |=> !r_valid)
		else $error("report after encryption request");

endmodule

bind postgres_wire_message_monitor pwmm_checker u_pwmm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.r_valid     (report.valid),
	.r_ready     (report.ready),
	.r_direction (report.direction),
	.r_type      (report.message_type),
	.r_len       (report.message_length),
	.r_kind      (report.message_kind),
	.r_class     (report.statement_class),
	.r_commit    (report.commit_counted),
	.r_rollback  (report.rollback_counted),
	.r_err       (report.error_seen),
	.r_warn      (report.warning_seen),
	.r_auth      (report.auth_ok),
	.r_txn       (report.in_transaction_now)
);

// ----- tb/postgres_wire_message_monitor_tb.sv -----
// Testbench for the PostgreSQL wire message monitor: a short directed byte table, then
// interleaved random client/server message streams checked against a local framing model.
// Depends on pwmm_pkg, pwmm_if and the postgres_wire_message_monitor design files.
`timescale 1ns / 100ps

module postgres_wire_message_monitor_tb;
	import pwmm_pkg::*;

	typedef enum logic [1:0] {
		IDLE_NONE     = 2'd0,
		IDLE_SENDER   = 2'd1,
		IDLE_RECEIVER = 2'd2,
		IDLE_BOTH     = 2'd3
	} idle_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       from_fe;
		logic       typed;
		report_t    rep;
	} wire_row_t;

	localparam string FE_TYPES = "BCdcfDEHFpPQSX";
	localparam string BE_TYPES = "RK23CdcGHDIEVvnNAtS1sZT";

	localparam int RANDOM_BYTES = 1424;
	localparam int PHASE_BYTES = 356;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;

	localparam report_t NO_REPORT = '0;
	localparam report_t REP_STARTUP = '{direction: 1'b1, msg_type: 8'h00, msg_len: 32'd4,
		kind: KIND_STARTUP, cls: CLS_NONE, default: '0};
	localparam report_t REP_TERM = '{direction: 1'b1, msg_type: TYPE_TERMINATE, msg_len: 32'd4,
		kind: KIND_KNOWN, cls: CLS_NONE, default: '0};
	localparam report_t REP_AUTH = '{direction: 1'b0, msg_type: TYPE_AUTH, msg_len: 32'd8,
		kind: KIND_KNOWN, cls: CLS_NONE, auth: 1'b1, default: '0};
	localparam report_t REP_BE_UNKNOWN = '{direction: 1'b0, msg_type: 8'hFF, msg_len: 32'd4,
		kind: KIND_UNKNOWN, cls: CLS_NONE, default: '0};
	localparam report_t REP_FE_UNKNOWN = '{direction: 1'b1, msg_type: 8'h00, msg_len: 32'd4,
		kind: KIND_UNKNOWN, cls: CLS_NONE, default: '0};

	// startup with short length, then server auth-ok interleaved with a client terminate,
	// then unknown types 0xff (server, length field 4) and 0x00 (client, short length field)
	localparam wire_row_t DIRECTED_ROWS [28] = '{
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h03, 1'b1, 1'b1, REP_STARTUP},
		'{8'h52, 1'b0, 1'b0, NO_REPORT},
		'{8'h58, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h08, 1'b0, 1'b0, NO_REPORT},
		'{8'h04, 1'b1, 1'b1, REP_TERM},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b1, REP_AUTH},
		'{8'hFF, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h00, 1'b0, 1'b0, NO_REPORT},
		'{8'h04, 1'b0, 1'b1, REP_BE_UNKNOWN},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h00, 1'b1, 1'b0, NO_REPORT},
		'{8'h01, 1'b1, 1'b1, REP_FE_UNKNOWN}
	};

	logic clk = 1'b0;
	logic arst_n;

	pwmm_byte_if stream_ch();
	pwmm_report_if report_ch();

	postgres_wire_message_monitor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.report (report_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// framing model state
	logic        startup_free = 1'b1;
	logic        crypt_on = 1'b0;
	logic        txn_open = 1'b0;
	phase_t      frm_phase [2] = '{PH_TYPE, PH_TYPE};
	logic        frm_startup [2] = '{1'b0, 1'b0};
	logic [7:0]  frm_type [2] = '{8'h00, 8'h00};
	logic [31:0] frm_len [2] = '{32'd0, 32'd0};
	logic [31:0] frm_cnt [2] = '{32'd0, 32'd0};
	logic [31:0] start_code = '0;
	logic [63:0] cc_word = '0;
	logic [3:0]  cc_count = '0;
	logic        cc_closed = 1'b0;
	logic [63:0] be_tail = '0;
	logic        hit_verror = 1'b0;
	logic        hit_vwarning = 1'b0;
	logic        be_nonzero = 1'b0;

	report_t    expected_reports [$];
	logic [7:0] fe_bytes [$];
	logic [7:0] be_bytes [$];
	logic [7:0] msg_body [$];

	string cmd_words [12] = '{"BEGIN", "START", "COMMIT", "ROLLBACK", "SELECT", "INSERT",
		"UPDATE", "DELETE", "COMMITS", "SELEC", "ROLLBACKS", "begin"};

	idle_mode_t idle_mode = IDLE_NONE;
	logic       hold_request = 1'b0;
	logic       hold_done = 1'b0;
	int         hold_left = 0;
	int         failures = 0;
	int         bytes_sent = 0;
	int         reports_checked = 0;
	int         commits_seen = 0;
	int         rollbacks_seen = 0;
	int         errors_seen = 0;
	int         warnings_seen = 0;
	int         auths_seen = 0;

	function automatic logic type_listed(input string set, input logic [7:0] t);
		for (int i = 0; i < set.len(); i++)
			if (set[i] == t)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic string report_text(input report_t r);
		return $sformatf("dir %0d type %02h len %0d kind %0d cls %0d commit %0d rb %0d err %0d warn %0d auth %0d txn %0d",
			r.direction, r.msg_type, r.msg_len, r.kind, r.cls, r.commit, r.rollback,
			r.err, r.warn, r.auth, r.in_txn);
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic close_message(input logic d, output report_t rep);
		rep = '0;
		frm_phase[d] = PH_TYPE;
		rep.direction = d;
		rep.msg_len = frm_len[d];
		if (frm_startup[d]) begin
			if (start_code >= ENCRYPT_CODE_MIN) begin
				crypt_on = 1'b1;
				rep.kind = KIND_ENCRYPT;
			end else begin
				rep.kind = KIND_STARTUP;
			end
		end else begin
			rep.msg_type = frm_type[d];
			if (d) begin
				rep.kind = type_listed(FE_TYPES, frm_type[d]) ? KIND_KNOWN : KIND_UNKNOWN;
				if (frm_type[d] == TYPE_TERMINATE && txn_open) begin
					txn_open = 1'b0;
					rep.rollback = 1'b1;
				end
			end else begin
				rep.kind = type_listed(BE_TYPES, frm_type[d]) ? KIND_KNOWN : KIND_UNKNOWN;
				case (frm_type[d])
					TYPE_COMMAND: begin
						rep.cls = CLS_OTHER;
						rep.commit = 1'b1;
						if (cc_count == 4'd5 && (cc_word == WORD_BEGIN || cc_word == WORD_START)) begin
							rep.cls = CLS_BEGIN;
							rep.commit = 1'b0;
							txn_open = 1'b1;
						end else if (cc_count == 4'd8 && cc_word == WORD_ROLLBACK) begin
							rep.cls = CLS_ROLLBACK;
							rep.commit = 1'b0;
							rep.rollback = 1'b1;
							txn_open = 1'b0;
						end else if (cc_count == 4'd6) begin
							case (cc_word)
								WORD_COMMIT: begin
									rep.cls = CLS_COMMIT;
									txn_open = 1'b0;
								end
								WORD_SELECT: rep.cls = CLS_SELECT;
								WORD_INSERT: rep.cls = CLS_INSERT;
								WORD_UPDATE: rep.cls = CLS_UPDATE;
								WORD_DELETE: rep.cls = CLS_DELETE;
								default: ;
							endcase
						end
					end
					TYPE_ERROR: rep.err = hit_verror;
					TYPE_NOTICE: rep.warn = hit_vwarning;
					TYPE_AUTH: rep.auth = (frm_len[d] == 32'd8) && !be_nonzero;
					default: ;
				endcase
			end
		end
		rep.in_txn = txn_open;
	endtask

	// advances the model by one accepted byte; done is set when a message completes
	task automatic track_wire_byte(input logic [7:0] b, input logic d, output logic done,
		output report_t rep);
		done = 1'b0;
		rep = '0;
		if (crypt_on)
			return;
		case (frm_phase[d])
			PH_PAYLOAD: begin
				if (frm_startup[d] && frm_cnt[d] < 32'd4)
					start_code = {start_code[23:0], b};
				if (!d) begin
					if (!cc_closed) begin
						if (b == CHAR_SPACE || b == 8'h00)
							cc_closed = 1'b1;
						else if (cc_count < WORD_MAX) begin
							cc_word = {cc_word[55:0], b};
							cc_count++;
						end else
							cc_count = WORD_OVER;
					end
					be_tail = {be_tail[55:0], b};
					if (be_tail[47:0] == PAT_VERROR)
						hit_verror = 1'b1;
					if (be_tail == PAT_VWARNING)
						hit_vwarning = 1'b1;
					if (b != 8'h00)
						be_nonzero = 1'b1;
				end
				frm_cnt[d] = frm_cnt[d] + 32'd1;
				if (frm_cnt[d] >= frm_len[d] - 32'd4) begin
					close_message(d, rep);
					done = 1'b1;
				end
			end
			PH_LEN: begin
				frm_len[d] = {frm_len[d][23:0], b};
				frm_cnt[d] = frm_cnt[d] + 32'd1;
				if (frm_cnt[d] >= 32'd4) begin
					if (frm_len[d] < 32'd4)
						frm_len[d] = 32'd4;
					frm_cnt[d] = '0;
					if (frm_len[d] == 32'd4) begin
						close_message(d, rep);
						done = 1'b1;
					end else
						frm_phase[d] = PH_PAYLOAD;
				end
			end
			default: begin
				// new message; server-side scanners start over
				if (!d) begin
					cc_word = '0;
					cc_count = '0;
					cc_closed = 1'b0;
					be_tail = '0;
					hit_verror = 1'b0;
					hit_vwarning = 1'b0;
					be_nonzero = 1'b0;
				end
				frm_phase[d] = PH_LEN;
				if (startup_free) begin
					startup_free = 1'b0;
					start_code = '0;
					frm_startup[d] = 1'b1;
					frm_type[d] = 8'h00;
					frm_len[d] = {24'd0, b};
					frm_cnt[d] = 32'd1;
				end else begin
					frm_startup[d] = 1'b0;
					frm_type[d] = b;
					frm_len[d] = '0;
					frm_cnt[d] = '0;
				end
			end
		endcase
	endtask

	task automatic send_and_track(input logic [7:0] b, input logic d, input logic typed,
		input report_t typed_rep);
		int idle_pct;
		logic done;
		report_t pred;
		idle_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 15 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.data_byte <= b;
		stream_ch.from_frontend <= d;
		do
			@(posedge clk);
		while (stream_ch.ready !== 1'b1);
		track_wire_byte(b, d, done, pred);
		if (typed)
			expected_reports.push_back(typed_rep);
		else if (done)
			expected_reports.push_back(pred);
		bytes_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_body.push_back(s[i]);
	endtask

	task automatic add_random(input int n);
		repeat (n)
			msg_body.push_back($urandom_range(0, 255));
	endtask

	// frames msg_body behind type byte t; sometimes a length field of at most 4 with no payload
	task automatic queue_message(input logic d, input logic [7:0] t);
		logic [31:0] len;
		logic [7:0] frame [$];
		len = msg_body.size() + 4;
		if ($urandom_range(0, 99) < 8) begin
			len = $urandom_range(0, 4);
			msg_body.delete();
		end
		frame.push_back(t);
		for (int k = 3; k >= 0; k--)
			frame.push_back(len[8*k +: 8]);
		foreach (msg_body[k])
			frame.push_back(msg_body[k]);
		foreach (frame[k])
			if (d)
				fe_bytes.push_back(frame[k]);
			else
				be_bytes.push_back(frame[k]);
		msg_body.delete();
	endtask

	task automatic build_backend();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			pick = $urandom_range(0, 17);
			if (pick < 12)
				add_text(cmd_words[pick]);
			else if (pick == 12)
				repeat ($urandom_range(1, 12))
					msg_body.push_back($urandom_range(8'h41, 8'h5A));
			else if (pick == 13)
				add_random($urandom_range(1, 10));
			else if (pick >= 15)
				add_text(cmd_words[pick - 15]);
			// pick 14: empty command word
			case ($urandom_range(0, 3))
				0: begin
					add_text(" 0 1");
					msg_body.push_back(8'h00);
				end
				1: msg_body.push_back(8'h00);
				2: ; // word runs to the end of the message
				default: begin
					msg_body.push_back(CHAR_SPACE);
					add_random($urandom_range(0, 4));
				end
			endcase
			queue_message(1'b0, TYPE_COMMAND);
		end else if (pick < 47) begin
			add_random($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: add_text("VERRO");
				1: add_text("VFATAL");
				default: add_text("VERROR");
			endcase
			if ($urandom_range(0, 1)) begin
				msg_body.push_back(8'h00);
				add_random($urandom_range(0, 3));
			end
			queue_message(1'b0, TYPE_ERROR);
		end else if (pick < 57) begin
			add_random($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: add_text("VWARNIN");
				1: add_text("VNOTICE");
				default: add_text("VWARNING");
			endcase
			if ($urandom_range(0, 1)) begin
				msg_body.push_back(8'h00);
				add_random($urandom_range(0, 3));
			end
			queue_message(1'b0, TYPE_NOTICE);
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0, 1: repeat (4) msg_body.push_back(8'h00);
				2: add_random(4);
				default: repeat ($urandom_range(0, 8)) msg_body.push_back(8'h00);
			endcase
			queue_message(1'b0, TYPE_AUTH);
		end else if (pick < 88) begin
			add_random($urandom_range(0, 6));
			queue_message(1'b0, BE_TYPES[$urandom_range(0, BE_TYPES.len() - 1)]);
		end else begin
			add_random($urandom_range(0, 6));
			queue_message(1'b0, $urandom_range(0, 255));
		end
	endtask

	task automatic build_frontend();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			if ($urandom_range(0, 3) == 0)
				add_random(1);
			queue_message(1'b1, TYPE_TERMINATE);
		end else if (pick < 55) begin
			add_text(cmd_words[$urandom_range(0, 11)]);
			add_random($urandom_range(0, 6));
			msg_body.push_back(8'h00);
			queue_message(1'b1, 8'h51);
		end else if (pick < 80) begin
			add_random($urandom_range(0, 8));
			queue_message(1'b1, FE_TYPES[$urandom_range(0, FE_TYPES.len() - 1)]);
		end else begin
			add_random($urandom_range(0, 8));
			queue_message(1'b1, $urandom_range(0, 255));
		end
	endtask

	// report side: random backpressure, one long hold-off on request, in-order checking
	always @(posedge clk) begin : report_watch
		report_t got;
		report_t want;
		int stall_pct;
		if (report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
			got = {report_ch.direction, report_ch.message_type, report_ch.message_length,
				report_ch.message_kind, report_ch.statement_class, report_ch.commit_counted,
				report_ch.rollback_counted, report_ch.error_seen, report_ch.warning_seen,
				report_ch.auth_ok, report_ch.in_transaction_now};
			if (expected_reports.size() == 0)
				note_failure({"report with nothing expected: ", report_text(got)});
			else begin
				want = expected_reports.pop_front();
				reports_checked++;
				if (got !== want)
					note_failure({"report mismatch\n  exp ", report_text(want),
						"\n  got ", report_text(got)});
				commits_seen += want.commit;
				rollbacks_seen += want.rollback;
				errors_seen += want.err;
				warnings_seen += want.warn;
				auths_seen += want.auth;
			end
		end
		stall_pct = (idle_mode == IDLE_RECEIVER) ? 46 : (idle_mode == IDLE_BOTH) ? 15 : 0;
		if (hold_left > 0) begin
			hold_left--;
			report_ch.ready <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			report_ch.ready <= 1'b0;
		end else
			report_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin : stimulus
		logic [7:0] b;
		logic dir;
		int waited;
		arst_n <= 1'b0;
		stream_ch.valid <= 1'b0;
		stream_ch.data_byte <= 8'h00;
		stream_ch.from_frontend <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_and_track(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].from_fe,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rep);

		dir = 1'b0;
		for (int n = 0; n < RANDOM_BYTES; n++) begin
			if (n % PHASE_BYTES == 0)
				idle_mode = idle_mode_t'(n / PHASE_BYTES);
			// long report hold-off while bytes keep coming, to back up into the input
			if (n == PHASE_BYTES / 4)
				hold_request = 1'b1;
			if ($urandom_range(0, 3) == 0)
				dir = !dir;
			if (dir) begin
				if (fe_bytes.size() == 0)
					build_frontend();
				b = fe_bytes.pop_front();
			end else begin
				if (be_bytes.size() == 0)
					build_backend();
				b = be_bytes.pop_front();
			end
			send_and_track(b, dir, 1'b0, NO_REPORT);
		end
		stream_ch.valid <= 1'b0;
		idle_mode = IDLE_NONE;

		waited = 0;
		while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_reports.size() != 0)
			note_failure($sformatf("%0d expected reports never arrived",
				expected_reports.size()));

		$display("Sent %0d stream bytes, checked %0d message reports (%0d commits, %0d rollbacks,",
			bytes_sent, reports_checked, commits_seen, rollbacks_seen);
		$display("%0d errors, %0d warnings, %0d auth ok) under four idle phases; %0d failures.",
			errors_seen, warnings_seen, auths_seen, failures);
		if (failures == 0)
			$display("** postgres_wire_message_monitor: PASSED **");
		else
			$display("** postgres_wire_message_monitor: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Timeout: run did not finish, %0d reports still expected",
			expected_reports.size());
		$display("** postgres_wire_message_monitor: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
design/pwmm_pkg.sv
design/pwmm_if.sv
design/pwmm_scan.sv
design/pwmm_framer.sv
design/postgres_wire_message_monitor.sv
design/pwmm_checker.sv
tb/postgres_wire_message_monitor_tb.sv
